>>> rtl/scfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfr_pkg
// Shared types and constants of the serial command frame receiver.
// ----------------------------------------------------------------------------
package scfr_pkg;

	localparam int unsigned FRAME_STORE_DEPTH = 64;
	localparam int unsigned JOB_Q_DEPTH       = 2;
	localparam int unsigned LEN_W             = 7;
	localparam int unsigned CFG_IDX_W         = 3;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_START_DELIM = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_IND    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RSSI_REQ    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REPLY_FLAG  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ADDR_MODE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_LIMIT  = 3'd5;

	typedef enum logic [2:0] {
		KIND_PAYLOAD = 3'd0,
		KIND_EMPTY   = 3'd1,
		KIND_BAD_CS  = 3'd2,
		KIND_MATCH   = 3'd3,
		KIND_IGNORED = 3'd4
	} kind_t;

	typedef struct packed {
		logic [7:0]       start_delimiter;
		logic [7:0]       data_indication_code;
		logic [7:0]       rssi_request_code;
		logic [7:0]       reply_flag_bits;
		logic [1:0]       address_mode;
		logic [LEN_W-1:0] read_limit;
	} cfg_t;

	// one completed frame, as handed from the parser to the emitter
	typedef struct packed {
		kind_t            kind;
		logic [7:0]       rssi;
		logic [7:0]       command;
		logic [7:0]       pending;
		logic [LEN_W-1:0] count;
		logic [1:0]       prefix;
		logic             bank;
	} job_t;

	typedef struct packed {
		logic       en;
		logic       bank;
		logic [7:0] data;
	} store_wr_t;

	typedef struct packed {
		logic en;
		logic bank;
	} bank_rel_t;

endpackage

>>> rtl/scfr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfr_queue
// Small job FIFO between the frame parser and the result emitter.
// ----------------------------------------------------------------------------
module scfr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  scfr_pkg::job_t din,
	output logic          full,
	input  logic          pop,
	output scfr_pkg::job_t dout,
	output logic          empty
);
	import scfr_pkg::*;

	localparam int unsigned PTR_W = (JOB_Q_DEPTH > 1) ? $clog2(JOB_Q_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(JOB_Q_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(JOB_Q_DEPTH - 1);

	job_t             entry_q [JOB_Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(JOB_Q_DEPTH));
	assign empty = (count_q == '0);
	assign dout  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/scfr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfr_front
// Frame parser: tracks the frame phases, checks the XOR checksum, writes data
// bytes into the store bank and classifies each completed frame into a job.
// ----------------------------------------------------------------------------
module scfr_front #(
	parameter int unsigned DEPTH = scfr_pkg::FRAME_STORE_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     mode,
	input  logic [7:0]               value,
	input  scfr_pkg::cfg_t           cfg,
	input  logic                     q_full,
	output logic                     push,
	output scfr_pkg::job_t           job,
	output scfr_pkg::store_wr_t      wr,
	output logic [$clog2(DEPTH)-1:0] wr_idx,
	input  scfr_pkg::bank_rel_t      rel
);
	import scfr_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);

	typedef enum logic [4:0] {
		PH_DELIM = 5'b00001,
		PH_CMD   = 5'b00010,
		PH_LEN   = 5'b00100,
		PH_DATA  = 5'b01000,
		PH_CS    = 5'b10000
	} phase_t;

	phase_t           phase_q;
	logic [7:0]       cmd_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] cursor_q;
	logic [7:0]       xor_q;
	logic [7:0]       pending_q;
	logic [7:0]       rssi_q;
	logic [7:0]       store0_q;     // entry 0 as last written
	logic [7:0]       last_data_q;  // most recent data byte
	logic             wbank_q;
	logic [1:0]       busy_q;

	logic             acc;
	logic             byte_acc;
	logic [LEN_W-1:0] len_clamp;
	logic [LEN_W-1:0] cursor_nxt;
	logic [1:0]       prefix;
	logic signed [8:0] avail;
	logic [7:0]       nxt_rssi;
	logic [7:0]       nxt_pending;
	kind_t            nxt_kind;
	logic [LEN_W-1:0] nxt_count;

	// a data byte waits while its bank is still being read out; a checksum byte waits while the job queue is full
	assign in_stall = ((phase_q == PH_CS) && q_full) ||
	                  ((phase_q == PH_DATA) && busy_q[wbank_q]);
	assign acc      = in_valid && !in_stall;
	assign byte_acc = acc && !mode;
	assign push     = byte_acc && (phase_q == PH_CS);

	assign len_clamp  = (value > 8'(DEPTH)) ? LEN_W'(DEPTH) : value[LEN_W-1:0];
	assign cursor_nxt = cursor_q + 1'b1;

	assign wr.en   = byte_acc && (phase_q == PH_DATA);
	assign wr.bank = wbank_q;
	assign wr.data = value;
	assign wr_idx  = cursor_q[AW-1:0];

	always_comb begin
		case (cfg.address_mode)
			2'd1:    prefix = 2'd1;
			2'd2:    prefix = 2'd2;
			default: prefix = 2'd0;
		endcase
		avail = $signed({2'b00, len_q}) - 9'sd1 - $signed({7'b0, prefix});

		nxt_rssi    = rssi_q;
		nxt_pending = pending_q;
		nxt_count   = '0;
		if ((xor_q ^ value) != 8'h00) begin
			nxt_kind = KIND_BAD_CS;
		end else if (cmd_q == cfg.data_indication_code) begin
			if (len_q == '0) begin
				nxt_rssi = 8'h00;
				nxt_kind = KIND_IGNORED;
			end else begin
				nxt_rssi = last_data_q;
				if (avail <= 9'sd0 || cfg.read_limit == '0) begin
					nxt_kind = KIND_EMPTY;
				end else begin
					nxt_kind  = KIND_PAYLOAD;
					nxt_count = (avail > $signed({2'b00, cfg.read_limit})) ?
					            cfg.read_limit : avail[LEN_W-1:0];
				end
			end
		end else if (cmd_q == (cfg.rssi_request_code | cfg.reply_flag_bits)) begin
			if (pending_q == cfg.rssi_request_code) begin
				nxt_rssi    = store0_q;
				nxt_pending = 8'h00;
				nxt_kind    = KIND_MATCH;
			end else begin
				nxt_kind = KIND_IGNORED;
			end
		end else if (pending_q != 8'h00 &&
		             cmd_q == (pending_q | cfg.reply_flag_bits)) begin
			nxt_pending = 8'h00;
			nxt_kind    = KIND_MATCH;
		end else begin
			nxt_kind = KIND_IGNORED;
		end

		job.kind    = nxt_kind;
		job.rssi    = nxt_rssi;
		job.command = cmd_q;
		job.pending = nxt_pending;
		job.count   = nxt_count;
		job.prefix  = prefix;
		job.bank    = wbank_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_DELIM;
			cmd_q       <= '0;
			len_q       <= '0;
			cursor_q    <= '0;
			xor_q       <= '0;
			pending_q   <= '0;
			rssi_q      <= '0;
			store0_q    <= '0;
			last_data_q <= '0;
			wbank_q     <= 1'b0;
			busy_q      <= '0;
		end else begin
			if (rel.en) begin
				busy_q[rel.bank] <= 1'b0;
			end
			if (acc && mode) begin
				pending_q <= value;
			end else if (byte_acc) begin
				case (phase_q)
					PH_DELIM: begin
						if (value == cfg.start_delimiter) begin
							xor_q   <= value;
							phase_q <= PH_CMD;
						end
					end
					PH_CMD: begin
						cmd_q   <= value;
						xor_q   <= xor_q ^ value;
						phase_q <= PH_LEN;
					end
					PH_LEN: begin
						len_q    <= len_clamp;
						xor_q    <= xor_q ^ {1'b0, len_clamp};
						cursor_q <= '0;
						phase_q  <= (len_clamp != '0) ? PH_DATA : PH_CS;
					end
					PH_DATA: begin
						if (cursor_q == '0) begin
							store0_q <= value;
						end
						last_data_q <= value;
						xor_q       <= xor_q ^ value;
						cursor_q    <= cursor_nxt;
						if (cursor_nxt >= len_q) begin
							phase_q <= PH_CS;
						end
					end
					PH_CS: begin
						rssi_q    <= nxt_rssi;
						pending_q <= nxt_pending;
						phase_q   <= PH_DELIM;
						// payload frames take their bank with them; switch banks
						if (nxt_kind == KIND_PAYLOAD) begin
							busy_q[wbank_q] <= 1'b1;
							wbank_q         <= ~wbank_q;
						end
					end
					default: phase_q <= PH_DELIM;
				endcase
			end
		end
	end

endmodule

>>> rtl/scfr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfr_back
// Result emitter: holds the two-bank frame store, walks each job and sends
// its results through a registered read stage and an output register.
// ----------------------------------------------------------------------------
module scfr_back #(
	parameter int unsigned DEPTH = scfr_pkg::FRAME_STORE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	output logic                           pop,
	input  scfr_pkg::job_t                 job_in,
	input  scfr_pkg::store_wr_t            wr,
	input  logic [$clog2(DEPTH)-1:0]       wr_idx,
	output scfr_pkg::bank_rel_t            rel,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [2:0]                     kind,
	output logic [7:0]                     payload_byte,
	output logic signed [7:0]              signal_strength,
	output logic [7:0]                     frame_command,
	output logic [scfr_pkg::LEN_W-1:0]     payload_length,
	output logic [7:0]                     request_pending,
	output logic                           last
);
	import scfr_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);

	logic [7:0]       mem [2*DEPTH];
	logic [7:0]       rd_data_q;

	job_t             job_q;
	logic             act_q;
	logic [LEN_W-1:0] idx_q;

	logic             v_s1;
	job_t             job_s1;
	logic             last_s1;

	logic             out_valid_q;
	kind_t            kind_q;
	logic [7:0]       byte_q;
	logic [7:0]       rssi_q;
	logic [7:0]       cmd_q;
	logic [LEN_W-1:0] len_q;
	logic [7:0]       pend_q;
	logic             last_q;

	logic             adv_s1;
	logic             issue;
	logic             last_issue;
	logic             rd_en;
	logic [AW-1:0]    rd_off;

	assign adv_s1     = v_s1 && (!out_valid_q || !out_stall);
	assign issue      = act_q && (!v_s1 || adv_s1);
	assign last_issue = (job_q.kind != KIND_PAYLOAD) || (idx_q + 1'b1 == job_q.count);
	assign rd_en      = issue && (job_q.kind == KIND_PAYLOAD);
	assign rd_off     = idx_q[AW-1:0] + AW'(job_q.prefix);
	assign pop        = !act_q && !q_empty;

	// bank is free once its final byte has been read
	assign rel.en   = rd_en && last_issue;
	assign rel.bank = job_q.bank;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[{wr.bank, wr_idx}] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[{job_q.bank, rd_off}];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job_in;
		end
		if (issue) begin
			job_s1  <= job_q;
			last_s1 <= last_issue;
		end
		if (adv_s1) begin
			kind_q <= job_s1.kind;
			byte_q <= (job_s1.kind == KIND_PAYLOAD) ? rd_data_q : 8'h00;
			rssi_q <= job_s1.rssi;
			cmd_q  <= job_s1.command;
			len_q  <= job_s1.count;
			pend_q <= job_s1.pending;
			last_q <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= 1'b0;
			idx_q       <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				act_q <= 1'b1;
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + 1'b1;
				if (last_issue) begin
					act_q <= 1'b0;
				end
			end
			if (issue) begin
				v_s1 <= 1'b1;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = kind_q;
	assign payload_byte    = byte_q;
	assign signal_strength = $signed(rssi_q);
	assign frame_command   = cmd_q;
	assign payload_length  = len_q;
	assign request_pending = pend_q;
	assign last            = last_q;

endmodule

>>> rtl/serial_command_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_frame_receiver
// Parses delimited, XOR-checked command frames from a UART byte stream and
// reports payload bytes, checksum errors and reply matches.
// ----------------------------------------------------------------------------
// Input bytes are taken one per cycle. A data byte waits while the store bank
// it would fill still holds an earlier frame's payload that is being read
// out, and a checksum byte waits while the two-entry job queue is full. Each
// completed frame gives its results one per cycle unless out_stall is high,
// limited by the single registered read port of the frame store; the first
// result passes the job queue, job register, read stage and output register.
// The two store banks of FRAME_STORE_DEPTH bytes need no clearing after reset.
module serial_command_frame_receiver #(
	parameter int unsigned FRAME_STORE_DEPTH = scfr_pkg::FRAME_STORE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             mode,
	input  logic [7:0]                       value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [2:0]                       kind,
	output logic [7:0]                       payload_byte,
	output logic signed [7:0]                signal_strength,
	output logic [7:0]                       frame_command,
	output logic [scfr_pkg::LEN_W-1:0]       payload_length,
	output logic [7:0]                       request_pending,
	output logic                             last,
	input  logic                             cfg_we,
	input  logic [scfr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [7:0]                       cfg_data
);
	import scfr_pkg::*;

	localparam int unsigned AW = $clog2(FRAME_STORE_DEPTH);

	cfg_t          cfg_q;
	logic          q_full;
	logic          q_empty;
	logic          push;
	logic          pop;
	job_t          job_push;
	job_t          job_pop;
	store_wr_t     wr;
	logic [AW-1:0] wr_idx;
	bank_rel_t     rel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_delimiter      <= 8'd2;
			cfg_q.data_indication_code <= 8'd129;
			cfg_q.rssi_request_code    <= 8'd13;
			cfg_q.reply_flag_bits      <= 8'd64;
			cfg_q.address_mode         <= 2'd0;
			cfg_q.read_limit           <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_DELIM: cfg_q.start_delimiter      <= cfg_data;
				CFG_DATA_IND:    cfg_q.data_indication_code <= cfg_data;
				CFG_RSSI_REQ:    cfg_q.rssi_request_code    <= cfg_data;
				CFG_REPLY_FLAG:  cfg_q.reply_flag_bits      <= cfg_data;
				CFG_ADDR_MODE:   cfg_q.address_mode         <= cfg_data[1:0];
				CFG_READ_LIMIT:  cfg_q.read_limit           <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	scfr_front #(
		.DEPTH(FRAME_STORE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode    (mode),
		.value   (value),
		.cfg     (cfg_q),
		.q_full  (q_full),
		.push    (push),
		.job     (job_push),
		.wr      (wr),
		.wr_idx  (wr_idx),
		.rel     (rel)
	);

	scfr_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (job_push),
		.full  (q_full),
		.pop   (pop),
		.dout  (job_pop),
		.empty (q_empty)
	);

	scfr_back #(
		.DEPTH(FRAME_STORE_DEPTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.pop            (pop),
		.job_in         (job_pop),
		.wr             (wr),
		.wr_idx         (wr_idx),
		.rel            (rel),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.payload_byte   (payload_byte),
		.signal_strength(signal_strength),
		.frame_command  (frame_command),
		.payload_length (payload_length),
		.request_pending(request_pending),
		.last           (last)
	);

endmodule

>>> rtl/scfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfr_checker
// Port-level checks of the frame receiver's result stream.
// ----------------------------------------------------------------------------
module scfr_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [2:0]                     kind,
	input logic [7:0]                     payload_byte,
	input logic signed [7:0]              signal_strength,
	input logic [7:0]                     frame_command,
	input logic [scfr_pkg::LEN_W-1:0]     payload_length,
	input logic [7:0]                     request_pending,
	input logic                           last
);
	import scfr_pkg::*;

	// a held result keeps its contents
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) &&
		$stable(payload_byte) && $stable(payload_length) && $stable(last))
		else $error("held result changed");

	// status results stand alone
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_PAYLOAD |-> last && payload_byte == 8'h00 &&
		payload_length == '0)
		else $error("status result malformed");

	// a payload run always reports a nonzero length
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_PAYLOAD |-> payload_length != '0)
		else $error("payload result with zero length");

	// within a run, frame fields stay fixed from one byte to the next
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && kind == KIND_PAYLOAD && !last ##1 out_valid |->
		kind == KIND_PAYLOAD && $stable(payload_length) && $stable(frame_command) &&
		$stable(signal_strength) && $stable(request_pending))
		else $error("payload run fields changed");

endmodule

bind serial_command_frame_receiver scfr_checker u_scfr_checker (.*);
